FILE: rtl/core/rexp_pkg.sv
// Shared types, codes and field widths of the ring exclusion process block.
`default_nettype none

package rexp_pkg;

   // Default sizes of the top level parameters.
   localparam int DEFAULT_SITES      = 256;
   localparam int DEFAULT_PARTICLES  = 64;
   localparam int DEFAULT_COUNT_BITS = 32;

   // Fixed widths of the channel fields.
   localparam int ACTION_W     = 2;
   localparam int PARTICLE_W   = 6;
   localparam int SITE_FIELD_W = 8;
   localparam int RANDOM_W     = 16;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 32;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 17;
   localparam int PROB_W       = 17;
   localparam int LEN_CFG_W    = 9;

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_W-1:0] CSR_HOP_PROB_FREE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOP_PROB_BLOCKED = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SITES_IN_USE     = 2'd2;

   // Register values after reset.
   localparam logic [PROB_W-1:0]    HOP_PROB_FREE_RESET    = 17'd32768;
   localparam logic [PROB_W-1:0]    HOP_PROB_BLOCKED_RESET = 17'd0;
   localparam logic [LEN_CFG_W-1:0] SITES_IN_USE_RESET     = 9'd256;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_PLACE  = 2'd1,
      ACT_UPDATE = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_OCCUPIED = 2'd1,
      STAT_RANGE    = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_PLACE,
      ST_READOUT,
      ST_UPD_CUR,
      ST_UPD_NXT,
      ST_UPD_CNT,
      ST_UPD_WR_CUR,
      ST_UPD_WR_NXT,
      ST_REPLY
   } state_type;

   typedef struct packed {
      status_type              status;
      logic                    occupied;
      logic                    moved;
      logic [PARTICLE_W-1:0]   mover;
      logic [SITE_FIELD_W-1:0] from_site;
      logic [SITE_FIELD_W-1:0] to_site;
      logic [COUNT_W-1:0]      visit_count;
      logic [COUNT_W-1:0]      hop_count;
      logic [COUNT_W-1:0]      site_visits;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: rtl/core/rexp_if.sv
// Channel interfaces: request words, response words and register writes.
`default_nettype none

interface rexp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [rexp_pkg::ACTION_W-1:0]        action;
   logic [rexp_pkg::PARTICLE_W-1:0]      particle;
   logic [rexp_pkg::SITE_FIELD_W-1:0]    site;
   logic [rexp_pkg::RANDOM_W-1:0]        random;

   modport source (output valid, action, particle, site, random, input ready);
   modport sink   (input valid, action, particle, site, random, output ready);
endinterface

interface rexp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [rexp_pkg::STATUS_W-1:0]        status;
   logic                                 occupied;
   logic                                 moved;
   logic [rexp_pkg::PARTICLE_W-1:0]      mover;
   logic [rexp_pkg::SITE_FIELD_W-1:0]    from_site;
   logic [rexp_pkg::SITE_FIELD_W-1:0]    to_site;
   logic [rexp_pkg::COUNT_W-1:0]         visit_count;
   logic [rexp_pkg::COUNT_W-1:0]         hop_count;
   logic [rexp_pkg::COUNT_W-1:0]         site_visits;

   modport source (output valid, status, occupied, moved, mover, from_site, to_site,
                   visit_count, hop_count, site_visits, input ready);
   modport sink   (input valid, status, occupied, moved, mover, from_site, to_site,
                   visit_count, hop_count, site_visits, output ready);
endinterface

interface rexp_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [rexp_pkg::CSR_INDEX_W-1:0]     index;
   logic [rexp_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ring_exclusion_process_step.sv
// A place or a read goes through LOOKUP, then PLACE or READOUT; an update goes through
// UPD_CUR and UPD_NXT, and for an occupied site UPD_CNT, UPD_WR_CUR and, on a hop, UPD_WR_NXT.
// Every word ends in REPLY. A new word is taken only while idle, once the last response is registered.
// A clear sweeps all memories, one address a cycle, over 2^(particle index bits + site index bits)
// addresses (16384 at the defaults). The same pass runs after reset, with no request accepted
// until it ends; register writes are taken at any time.
`default_nettype none

module ring_exclusion_process_step #(
   parameter int SITES      = rexp_pkg::DEFAULT_SITES,
   parameter int PARTICLES  = rexp_pkg::DEFAULT_PARTICLES,
   parameter int COUNT_BITS = rexp_pkg::DEFAULT_COUNT_BITS
) (
   input  wire          clock,
   input  wire          reset,
   rexp_req_if.sink     req_bus,
   rexp_rsp_if.source   rsp_bus,
   rexp_csr_if.sink     csr_bus
);

   // Site index width, particle index width and counter address width.
   localparam int SW         = $clog2(SITES);
   localparam int PW         = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
   localparam int CW         = COUNT_BITS;
   localparam int AW         = PW + SW;
   localparam int SITE_DEPTH = 1 << SW;
   localparam int CNT_DEPTH  = 1 << AW;
   // Ring length arithmetic needs room for SITES itself and for the 9-bit register.
   localparam int LEN_W      = (SW + 1 > 10) ? SW + 1 : 10;

   // One site memory word: occupancy, owner and the total visit count of the site.
   typedef struct packed {
      logic          occ;
      logic [PW-1:0] owner;
      logic [CW-1:0] visits;
   } site_entry_type;

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      sat_inc = (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [SW-1:0] site_index(input logic [7:0] s);
      logic [SW+7:0] w;
      w = {{SW{1'b0}}, s};
      site_index = w[SW-1:0];
   endfunction

   function automatic logic [PW-1:0] part_index(input logic [5:0] p);
      logic [PW+5:0] w;
      w = {{PW{1'b0}}, p};
      part_index = w[PW-1:0];
   endfunction

   function automatic logic [7:0] site_byte(input logic [SW-1:0] s);
      logic [SW+7:0] w;
      w = {8'b0, s};
      site_byte = w[7:0];
   endfunction

   function automatic logic [5:0] part_byte(input logic [PW-1:0] p);
      logic [PW+5:0] w;
      w = {6'b0, p};
      part_byte = w[5:0];
   endfunction

   function automatic logic [31:0] count_word(input logic [CW-1:0] c);
      logic [CW+31:0] w;
      w = {32'b0, c};
      count_word = w[31:0];
   endfunction

   // Control state.
   rexp_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       clr_addr_ff;
   logic                clr_reply_ff;
   logic [SW-1:0]       sweep_ff;
   logic                behind_ff;
   logic                rsp_valid_ff;

   // Configuration registers.
   logic [rexp_pkg::PROB_W-1:0]    prob_free_ff;
   logic [rexp_pkg::PROB_W-1:0]    prob_blocked_ff;
   logic [rexp_pkg::LEN_CFG_W-1:0] sites_in_use_ff;

   // The word under work and the values carried between its steps.
   rexp_pkg::action_type act_ff;
   logic [PW-1:0]        part_ff;
   logic [SW-1:0]        site_ff;
   logic [15:0]          rnd_ff;
   logic                 range_bad_ff;
   logic [SW-1:0]        cur_ff;
   logic [SW-1:0]        nxt_ff;
   site_entry_type       cur_entry_ff;
   logic                 hop_ff;
   logic [CW-1:0]        sv_nxt_ff;
   rexp_pkg::rsp_word_type res_ff;
   rexp_pkg::rsp_word_type rsp_word_ff;

   // Memories and their ports.
   site_entry_type site_mem [SITE_DEPTH];
   logic [CW-1:0]  visit_mem [CNT_DEPTH];
   logic [CW-1:0]  hop_mem [CNT_DEPTH];

   site_entry_type site_rdata_ff;
   logic [CW-1:0]  visit_rdata_ff;
   logic [CW-1:0]  hop_rdata_ff;

   logic [SW-1:0]  site_raddr;
   logic           site_we;
   logic [SW-1:0]  site_waddr;
   site_entry_type site_wdata;
   logic [AW-1:0]  visit_raddr;
   logic           visit_we;
   logic [AW-1:0]  visit_waddr;
   logic [CW-1:0]  visit_wdata;
   logic [AW-1:0]  hop_raddr;
   logic           hop_we;
   logic [AW-1:0]  hop_waddr;
   logic [CW-1:0]  hop_wdata;

   // Handshakes.
   logic req_fire;
   logic csr_fire;
   logic out_free;

   assign req_bus.ready = (state_ff == rexp_pkg::ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid;
   // The output register can take a new word when it is empty or being emptied.
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // Ring length, clamped to the range the memories can hold.
   logic [LEN_W-1:0] len_cfg_ext;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] len_m1;
   logic [LEN_W-1:0] sweep_ext;
   logic [LEN_W-1:0] cur_inc;
   logic [SW-1:0]    cur_idx;
   logic [SW-1:0]    nxt_idx;
   logic [SW-1:0]    sweep_next;

   assign len_cfg_ext = {{(LEN_W - rexp_pkg::LEN_CFG_W){1'b0}}, sites_in_use_ff};

   always_comb begin
      if (len_cfg_ext < LEN_W'(2)) begin
         len = LEN_W'(2);
      end else if (len_cfg_ext > LEN_W'(SITES)) begin
         len = LEN_W'(SITES);
      end else begin
         len = len_cfg_ext;
      end
   end

   // The sweep pointer restarts at site 0 if the ring shrank below it. The site ahead
   // is one step down, with site 0 wrapping to the top of the ring.
   assign len_m1    = len - 1'b1;
   assign sweep_ext = {{(LEN_W - SW){1'b0}}, sweep_ff};
   assign cur_idx   = (sweep_ext >= len) ? '0 : sweep_ff;
   assign nxt_idx   = (cur_idx == '0) ? len_m1[SW-1:0] : cur_idx - 1'b1;
   assign cur_inc   = {{(LEN_W - SW){1'b0}}, cur_idx} + 1'b1;
   assign sweep_next = (cur_inc >= len) ? '0 : cur_inc[SW-1:0];

   // Hop decision, taken while the site ahead is on the site memory read port.
   // The probability follows whether the previously swept site held a particle.
   logic [rexp_pkg::PROB_W-1:0] prob;
   logic                        hop_now;
   logic [PW-1:0]               who;

   assign prob    = behind_ff ? prob_blocked_ff : prob_free_ff;
   assign hop_now = !site_rdata_ff.occ && ({1'b0, rnd_ff} < prob);
   assign who     = cur_entry_ff.owner;

   // Range check of place and read words, done as the word is accepted.
   logic req_range_bad;

   assign req_range_bad =
      ({{(LEN_W - rexp_pkg::SITE_FIELD_W){1'b0}}, req_bus.site} >= len) ||
      (32'(req_bus.particle) >= 32'(PARTICLES));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rexp_pkg::ST_CLEAR: begin
            if (&clr_addr_ff) begin
               state_in = clr_reply_ff ? rexp_pkg::ST_REPLY : rexp_pkg::ST_IDLE;
            end
         end
         rexp_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.action)
                  rexp_pkg::ACT_CLEAR:  state_in = rexp_pkg::ST_CLEAR;
                  rexp_pkg::ACT_UPDATE: state_in = rexp_pkg::ST_UPD_CUR;
                  default:              state_in = rexp_pkg::ST_LOOKUP;
               endcase
            end
         end
         rexp_pkg::ST_LOOKUP: begin
            state_in = (act_ff == rexp_pkg::ACT_PLACE) ? rexp_pkg::ST_PLACE
                                                       : rexp_pkg::ST_READOUT;
         end
         rexp_pkg::ST_PLACE:   state_in = rexp_pkg::ST_REPLY;
         rexp_pkg::ST_READOUT: state_in = rexp_pkg::ST_REPLY;
         rexp_pkg::ST_UPD_CUR: state_in = rexp_pkg::ST_UPD_NXT;
         rexp_pkg::ST_UPD_NXT: begin
            state_in = site_rdata_ff.occ ? rexp_pkg::ST_UPD_CNT : rexp_pkg::ST_REPLY;
         end
         rexp_pkg::ST_UPD_CNT: state_in = rexp_pkg::ST_UPD_WR_CUR;
         rexp_pkg::ST_UPD_WR_CUR: begin
            state_in = hop_ff ? rexp_pkg::ST_UPD_WR_NXT : rexp_pkg::ST_REPLY;
         end
         rexp_pkg::ST_UPD_WR_NXT: state_in = rexp_pkg::ST_REPLY;
         rexp_pkg::ST_REPLY: begin
            if (out_free) begin
               state_in = rexp_pkg::ST_IDLE;
            end
         end
         default: state_in = rexp_pkg::ST_CLEAR;
      endcase
   end

   // Memory addresses and writes for each step.
   always_comb begin
      site_raddr  = cur_ff;
      site_we     = 1'b0;
      site_waddr  = cur_ff;
      site_wdata  = cur_entry_ff;
      visit_raddr = {part_ff, site_ff};
      visit_we    = 1'b0;
      visit_waddr = {part_ff, site_ff};
      visit_wdata = sat_inc(visit_rdata_ff);
      hop_raddr   = {part_ff, site_ff};
      hop_we      = 1'b0;
      hop_waddr   = {who, cur_ff};
      hop_wdata   = sat_inc(hop_rdata_ff);
      case (state_ff)
         rexp_pkg::ST_CLEAR: begin
            site_we     = 1'b1;
            site_waddr  = clr_addr_ff[SW-1:0];
            site_wdata  = '0;
            visit_we    = 1'b1;
            visit_waddr = clr_addr_ff;
            visit_wdata = '0;
            hop_we      = 1'b1;
            hop_waddr   = clr_addr_ff;
            hop_wdata   = '0;
         end
         rexp_pkg::ST_LOOKUP: begin
            site_raddr = site_ff;
         end
         rexp_pkg::ST_PLACE: begin
            if (!range_bad_ff && !site_rdata_ff.occ) begin
               site_we           = 1'b1;
               site_waddr        = site_ff;
               site_wdata.occ    = 1'b1;
               site_wdata.owner  = part_ff;
               site_wdata.visits = sat_inc(site_rdata_ff.visits);
               visit_we          = 1'b1;
            end
         end
         rexp_pkg::ST_UPD_CUR: begin
            site_raddr = cur_idx;
         end
         rexp_pkg::ST_UPD_NXT: begin
            site_raddr = nxt_ff;
         end
         rexp_pkg::ST_UPD_CNT: begin
            visit_raddr = {who, hop_now ? nxt_ff : cur_ff};
            hop_raddr   = {who, cur_ff};
         end
         rexp_pkg::ST_UPD_WR_CUR: begin
            // The particle either leaves the swept site or is counted there again.
            visit_we    = 1'b1;
            visit_waddr = {who, hop_ff ? nxt_ff : cur_ff};
            hop_we      = hop_ff;
            site_we     = 1'b1;
            site_waddr  = cur_ff;
            if (hop_ff) begin
               site_wdata.occ = 1'b0;
            end else begin
               site_wdata.visits = sat_inc(cur_entry_ff.visits);
            end
         end
         rexp_pkg::ST_UPD_WR_NXT: begin
            site_we           = 1'b1;
            site_waddr        = nxt_ff;
            site_wdata.occ    = 1'b1;
            site_wdata.owner  = who;
            site_wdata.visits = sat_inc(sv_nxt_ff);
         end
         default: begin
         end
      endcase
   end

   // Memories: one write and one registered read per cycle each.
   always_ff @(posedge clock) begin
      if (site_we) begin
         site_mem[site_waddr] <= site_wdata;
      end
      site_rdata_ff <= site_mem[site_raddr];
   end

   always_ff @(posedge clock) begin
      if (visit_we) begin
         visit_mem[visit_waddr] <= visit_wdata;
      end
      visit_rdata_ff <= visit_mem[visit_raddr];
   end

   always_ff @(posedge clock) begin
      if (hop_we) begin
         hop_mem[hop_waddr] <= hop_wdata;
      end
      hop_rdata_ff <= hop_mem[hop_raddr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= rexp_pkg::ST_CLEAR;
         clr_addr_ff     <= '0;
         clr_reply_ff    <= 1'b0;
         sweep_ff        <= '0;
         behind_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         prob_free_ff    <= rexp_pkg::HOP_PROB_FREE_RESET;
         prob_blocked_ff <= rexp_pkg::HOP_PROB_BLOCKED_RESET;
         sites_in_use_ff <= rexp_pkg::SITES_IN_USE_RESET;
      end else begin
         state_ff <= state_in;

         if (csr_fire) begin
            case (csr_bus.index)
               rexp_pkg::CSR_HOP_PROB_FREE:    prob_free_ff <= csr_bus.data;
               rexp_pkg::CSR_HOP_PROB_BLOCKED: prob_blocked_ff <= csr_bus.data;
               rexp_pkg::CSR_SITES_IN_USE: begin
                  sites_in_use_ff <= csr_bus.data[rexp_pkg::LEN_CFG_W-1:0];
               end
               default: begin
               end
            endcase
         end

         case (state_ff)
            rexp_pkg::ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
            end
            rexp_pkg::ST_IDLE: begin
               if (req_fire && req_bus.action == rexp_pkg::ACT_CLEAR) begin
                  clr_addr_ff  <= '0;
                  clr_reply_ff <= 1'b1;
                  sweep_ff     <= '0;
                  behind_ff    <= 1'b0;
               end
            end
            rexp_pkg::ST_UPD_CUR: begin
               sweep_ff <= sweep_next;
            end
            rexp_pkg::ST_UPD_NXT: begin
               if (!site_rdata_ff.occ) begin
                  behind_ff <= 1'b0;
               end
            end
            rexp_pkg::ST_UPD_CNT: begin
               // The probability for this site was taken from the old value above.
               behind_ff <= 1'b1;
            end
            default: begin
            end
         endcase

         if (state_ff == rexp_pkg::ST_REPLY && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: the accepted word, values between steps and the response.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff       <= rexp_pkg::action_type'(req_bus.action);
         part_ff      <= part_index(req_bus.particle);
         site_ff      <= site_index(req_bus.site);
         rnd_ff       <= req_bus.random;
         range_bad_ff <= req_range_bad;
      end

      case (state_ff)
         rexp_pkg::ST_CLEAR: begin
            res_ff <= '0;
         end
         rexp_pkg::ST_PLACE: begin
            if (range_bad_ff) begin
               res_ff <= '{status: rexp_pkg::STAT_RANGE, default: '0};
            end else if (site_rdata_ff.occ) begin
               res_ff <= '{status: rexp_pkg::STAT_OCCUPIED, default: '0};
            end else begin
               res_ff <= '{status: rexp_pkg::STAT_OK, default: '0};
            end
         end
         rexp_pkg::ST_READOUT: begin
            if (range_bad_ff) begin
               res_ff <= '{status: rexp_pkg::STAT_RANGE, default: '0};
            end else begin
               res_ff <= '{status:      rexp_pkg::STAT_OK,
                           visit_count: count_word(visit_rdata_ff),
                           hop_count:   count_word(hop_rdata_ff),
                           site_visits: count_word(site_rdata_ff.visits),
                           default:     '0};
            end
         end
         rexp_pkg::ST_UPD_CUR: begin
            cur_ff <= cur_idx;
            nxt_ff <= nxt_idx;
         end
         rexp_pkg::ST_UPD_NXT: begin
            // Response for an empty site; overwritten later if it is occupied.
            cur_entry_ff <= site_rdata_ff;
            res_ff       <= '{status:    rexp_pkg::STAT_OK,
                              from_site: site_byte(cur_ff),
                              to_site:   site_byte(cur_ff),
                              default:   '0};
         end
         rexp_pkg::ST_UPD_CNT: begin
            hop_ff    <= hop_now;
            sv_nxt_ff <= site_rdata_ff.visits;
         end
         rexp_pkg::ST_UPD_WR_CUR: begin
            res_ff.occupied <= 1'b1;
            res_ff.moved    <= hop_ff;
            res_ff.mover    <= part_byte(who);
            res_ff.to_site  <= site_byte(hop_ff ? nxt_ff : cur_ff);
         end
         rexp_pkg::ST_REPLY: begin
            if (out_free) begin
               rsp_word_ff <= res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_word_ff.status;
   assign rsp_bus.occupied    = rsp_word_ff.occupied;
   assign rsp_bus.moved       = rsp_word_ff.moved;
   assign rsp_bus.mover       = rsp_word_ff.mover;
   assign rsp_bus.from_site   = rsp_word_ff.from_site;
   assign rsp_bus.to_site     = rsp_word_ff.to_site;
   assign rsp_bus.visit_count = rsp_word_ff.visit_count;
   assign rsp_bus.hop_count   = rsp_word_ff.hop_count;
   assign rsp_bus.site_visits = rsp_word_ff.site_visits;

endmodule

`default_nettype wire

FILE: verif/rexp_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the response word of every accepted request.
`default_nettype none

package rexp_tb_pkg;
   import rexp_pkg::*;

   localparam int unsigned N_SITES     = DEFAULT_SITES;
   localparam int unsigned N_PARTICLES = DEFAULT_PARTICLES;

   class hop_scoreboard;
      bit                    occupancy [N_SITES];
      logic [PARTICLE_W-1:0] owner_of [N_SITES];
      logic [COUNT_W-1:0]    particle_visits [N_SITES*N_PARTICLES];
      logic [COUNT_W-1:0]    particle_hops [N_SITES*N_PARTICLES];
      logic [COUNT_W-1:0]    visits_of_site [N_SITES];
      bit                    behind_busy;
      int unsigned           sweep_pos;
      logic [PROB_W-1:0]     prob_free;
      logic [PROB_W-1:0]     prob_blocked;
      logic [LEN_CFG_W-1:0]  ring_cfg;
      rsp_word_type          pending_words [$];
      int unsigned           mismatches;

      function new();
         prob_free    = HOP_PROB_FREE_RESET;
         prob_blocked = HOP_PROB_BLOCKED_RESET;
         ring_cfg     = SITES_IN_USE_RESET;
         mismatches   = 0;
         clear_stores();
      endfunction

      function void clear_stores();
         foreach (occupancy[i]) begin
            occupancy[i]      = 1'b0;
            owner_of[i]       = '0;
            visits_of_site[i] = '0;
         end
         foreach (particle_visits[i]) begin
            particle_visits[i] = '0;
            particle_hops[i]   = '0;
         end
         behind_busy = 1'b0;
         sweep_pos   = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] reg_index, logic [CSR_DATA_W-1:0] value);
         case (reg_index)
            CSR_HOP_PROB_FREE:    prob_free    = value;
            CSR_HOP_PROB_BLOCKED: prob_blocked = value;
            CSR_SITES_IN_USE:     ring_cfg     = value[LEN_CFG_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned ring_len();
         int unsigned l;
         l = ring_cfg;
         if (l < 2) l = 2;
         if (l > N_SITES) l = N_SITES;
         return l;
      endfunction

      // A pointer left beyond a shortened ring restarts the sweep at site 0.
      function int unsigned sweep_current();
         return (sweep_pos >= ring_len()) ? 0 : sweep_pos;
      endfunction

      function logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] c);
         return (c == '1) ? c : c + 1'b1;
      endfunction

      function void note_request(action_type act, logic [PARTICLE_W-1:0] part,
                                 logic [SITE_FIELD_W-1:0] site, logic [RANDOM_W-1:0] rnd);
         rsp_word_type      w;
         int unsigned       len, cur, nxt, who, slot;
         logic [PROB_W-1:0] prob;
         w    = '0;
         len  = ring_len();
         slot = int'(part) * N_SITES + int'(site);
         case (act)
            ACT_CLEAR: clear_stores();
            ACT_PLACE, ACT_READ: begin
               if (site >= len || part >= N_PARTICLES) begin
                  w.status = STAT_RANGE;
               end else if (act == ACT_PLACE) begin
                  if (occupancy[site]) begin
                     w.status = STAT_OCCUPIED;
                  end else begin
                     occupancy[site]       = 1'b1;
                     owner_of[site]        = part;
                     particle_visits[slot] = sat_inc(particle_visits[slot]);
                     visits_of_site[site]  = sat_inc(visits_of_site[site]);
                  end
               end else begin
                  w.visit_count = particle_visits[slot];
                  w.hop_count   = particle_hops[slot];
                  w.site_visits = visits_of_site[site];
               end
            end
            default: begin
               cur = sweep_current();
               nxt = (cur == 0) ? len - 1 : cur - 1;
               w.from_site = SITE_FIELD_W'(cur);
               w.to_site   = SITE_FIELD_W'(cur);
               if (occupancy[cur]) begin
                  who  = owner_of[cur];
                  prob = behind_busy ? prob_blocked : prob_free;
                  w.occupied = 1'b1;
                  w.mover    = PARTICLE_W'(who);
                  if (!occupancy[nxt] && rnd < prob) begin
                     occupancy[cur] = 1'b0;
                     occupancy[nxt] = 1'b1;
                     owner_of[nxt]  = PARTICLE_W'(who);
                     particle_visits[who*N_SITES+nxt] = sat_inc(particle_visits[who*N_SITES+nxt]);
                     particle_hops[who*N_SITES+cur]   = sat_inc(particle_hops[who*N_SITES+cur]);
                     visits_of_site[nxt] = sat_inc(visits_of_site[nxt]);
                     w.moved   = 1'b1;
                     w.to_site = SITE_FIELD_W'(nxt);
                  end else begin
                     particle_visits[who*N_SITES+cur] = sat_inc(particle_visits[who*N_SITES+cur]);
                     visits_of_site[cur] = sat_inc(visits_of_site[cur]);
                  end
                  behind_busy = 1'b1;
               end else begin
                  behind_busy = 1'b0;
               end
               cur++;
               if (cur >= len) cur = 0;
               sweep_pos = cur;
            end
         endcase
         pending_words.push_back(w);
      endfunction

      function void compare_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (pending_words.size() == 0) begin
            $error("response word arrived with no request waiting");
            mismatches++;
            return;
         end
         want = pending_words.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("occupied", want.occupied, got.occupied);
         compare_field("moved", want.moved, got.moved);
         compare_field("mover", want.mover, got.mover);
         compare_field("from_site", want.from_site, got.from_site);
         compare_field("to_site", want.to_site, got.to_site);
         compare_field("visit_count", want.visit_count, got.visit_count);
         compare_field("hop_count", want.hop_count, got.hop_count);
         compare_field("site_visits", want.site_visits, got.site_visits);
      endfunction
   endclass

endpackage

`default_nettype wire

FILE: verif/testbench.sv
// Top level of the testbench: clock, reset, request and register drivers, response checker.
`default_nettype none

module testbench;
   import rexp_pkg::*;
   import rexp_tb_pkg::*;

   // Index 3 has no register behind it; a write there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // A clear sweeps every memory address (16384 at the defaults) and the same pass runs
   // after reset, so the watchdog must tolerate that plus the long response hold-off.
   localparam int unsigned IDLE_LIMIT      = 60000;
   localparam int unsigned HOLD_CYCLES     = 400;
   localparam int unsigned SETTLE_CYCLES   = 10;
   localparam int unsigned PHASES          = 10;
   localparam int unsigned ITEMS_PER_PHASE = 115;

   logic clock = 1'b0;
   logic reset;

   rexp_req_if req_bus ();
   rexp_rsp_if rsp_bus ();
   rexp_csr_if csr_bus ();

   hop_scoreboard sb;

   // Sender idling state, and the request for a long response hold-off.
   bit          send_burst;
   bit          pressure_on;
   bit          hold_rsp;

   // Register settings of the random phases; the last phase draws its own values.
   int unsigned phase_free    [PHASES] = '{32768,     0, 65536, 131071, 20000,
                                           32768, 50000,     0,  65535,     0};
   int unsigned phase_blocked [PHASES] = '{16384, 65536,     0, 131071, 40000,
                                           32768, 10000,     0,  65535,     0};
   int unsigned phase_len     [PHASES] = '{  256,     8,     2,      0,     5,
                                               1,   511,    16,    300,     0};

   always #1 clock = ~clock;

   ring_exclusion_process_step i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Idle gap after a request word: mostly none or short, a few long. Burst stretches
   // with no gaps at all come and go at random.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      if (send_burst || pressure_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offers one request word, waits for the handshake, tells the scoreboard and idles.
   // Called at a rising edge; valid stays high when the next word follows directly.
   task automatic issue_request(input action_type act, input int unsigned part,
                                input int unsigned site, input int unsigned rnd);
      int unsigned gap;
      req_bus.valid    <= 1'b1;
      req_bus.action   <= act;
      req_bus.particle <= PARTICLE_W'(part);
      req_bus.site     <= SITE_FIELD_W'(site);
      req_bus.random   <= RANDOM_W'(rnd);
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(act, PARTICLE_W'(part), SITE_FIELD_W'(site), RANDOM_W'(rnd));
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] reg_index, input int unsigned value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= reg_index;
      csr_bus.data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(reg_index, CSR_DATA_W'(value));
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stops offering requests and waits until every predicted word has come back, then
   // lets the block settle so it is idle before a register write.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random request word. Placements lean toward the sites just ahead of the sweep
   // so that particles get swept and hop, reads lean toward the sites just swept and
   // toward their owners so that counters are seen nonzero, and the random word of an
   // update sometimes sits right at a hop probability. A small share of place and read
   // words uses the full index ranges so that range errors occur on short rings.
   task automatic random_item();
      int unsigned len, r, part, site, rnd, cur, p;
      action_type  act;
      len  = sb.ring_len();
      cur  = sb.sweep_current();
      r    = $urandom_range(0, 999);
      part = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
      site = $urandom_range(0, len - 1);
      rnd  = $urandom_range(0, 65535);
      if (r < 6) act = ACT_CLEAR;
      else if (r < 300) act = ACT_PLACE;
      else if (r < 820) act = ACT_UPDATE;
      else act = ACT_READ;
      case (act)
         ACT_PLACE: begin
            if ($urandom_range(0, 1)) site = (cur + $urandom_range(0, 6)) % len;
         end
         ACT_READ: begin
            if ($urandom_range(0, 1)) site = (cur + 8 * len - $urandom_range(1, 6)) % len;
            if (sb.occupancy[site] && $urandom_range(0, 3) != 0) part = sb.owner_of[site];
         end
         ACT_UPDATE: begin
            if ($urandom_range(0, 4) == 0) begin
               p = $urandom_range(0, 1) ? sb.prob_free : sb.prob_blocked;
               if (p > 0) p = p - $urandom_range(0, 1);
               rnd = (p > 65535) ? 65535 : p;
            end
         end
         default: ;
      endcase
      if ((act == ACT_PLACE || act == ACT_READ) && $urandom_range(0, 9) == 0) begin
         site = $urandom_range(0, 255);
         part = $urandom_range(0, 63);
      end
      issue_request(act, part, site, rnd);
   endtask

   // Response side: checks every accepted word and stalls at random. When asked, it holds
   // ready low for a long stretch of its own counting so that the block backs up.
   initial begin : response_side
      int unsigned  stretch, hold_left, r;
      logic         level;
      rsp_word_type seen;
      rsp_bus.ready <= 1'b0;
      stretch   = 0;
      hold_left = 0;
      level     = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.status      = status_type'(rsp_bus.status);
            seen.occupied    = rsp_bus.occupied;
            seen.moved       = rsp_bus.moved;
            seen.mover       = rsp_bus.mover;
            seen.from_site   = rsp_bus.from_site;
            seen.to_site     = rsp_bus.to_site;
            seen.visit_count = rsp_bus.visit_count;
            seen.hop_count   = rsp_bus.hop_count;
            seen.site_visits = rsp_bus.site_visits;
            sb.check_response(seen);
         end
         if (hold_rsp && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_rsp  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            level = 1'b0;
         end else if (stretch == 0) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               level   = 1'b1;
               stretch = $urandom_range(1, 8);
            end else if (r < 75) begin
               level   = 1'b1;
               stretch = $urandom_range(30, 120);
            end else if (r < 95) begin
               level   = 1'b0;
               stretch = $urandom_range(1, 4);
            end else begin
               level   = 1'b0;
               stretch = $urandom_range(15, 60);
            end
         end else begin
            stretch--;
         end
         rsp_bus.ready <= level;
      end
   end

   // Watchdog: ends the run when no word moves on any channel for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase, n, p_free, p_blocked, len;
      sb = new();
      send_burst  = 1'b0;
      pressure_on = 1'b0;
      hold_rsp    = 1'b0;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.action   <= ACT_CLEAR;
      req_bus.particle <= '0;
      req_bus.site     <= '0;
      req_bus.random   <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= CSR_HOP_PROB_FREE;
      csr_bus.data     <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed words with the reset register values. The block runs its clearing pass
      // first, so the first word simply waits for ready.
      issue_request(ACT_READ, 0, 0, 0);
      issue_request(ACT_PLACE, 63, 255, 65535);
      issue_request(ACT_PLACE, 0, 0, 0);
      issue_request(ACT_PLACE, 5, 0, 0);         // site already occupied
      issue_request(ACT_PLACE, 0, 3, 0);         // same particle placed on a second site
      issue_request(ACT_UPDATE, 0, 0, 0);        // site 0, wrap target 255 occupied
      issue_request(ACT_UPDATE, 0, 0, 0);        // empty site
      issue_request(ACT_READ, 63, 255, 0);
      issue_request(ACT_READ, 0, 0, 0);
      issue_request(ACT_CLEAR, 63, 255, 65535);
      drain();

      // A three site ring with a certain hop after an empty site and none after a busy one.
      csr_write(CSR_SITES_IN_USE, 3);
      csr_write(CSR_HOP_PROB_FREE, 65536);
      issue_request(ACT_PLACE, 1, 1, 0);
      issue_request(ACT_PLACE, 2, 255, 0);       // site beyond the ring in use
      issue_request(ACT_READ, 0, 3, 0);          // site beyond the ring in use
      issue_request(ACT_UPDATE, 0, 0, 65535);    // empty site 0
      issue_request(ACT_UPDATE, 0, 0, 65535);    // hop from site 1 to 0
      issue_request(ACT_UPDATE, 0, 0, 65535);    // empty site 2
      issue_request(ACT_UPDATE, 0, 0, 65535);    // hop from site 0 wrapping to 2
      issue_request(ACT_PLACE, 4, 0, 0);
      issue_request(ACT_UPDATE, 0, 0, 0);        // empty site 1
      issue_request(ACT_UPDATE, 0, 0, 0);        // hop from site 2 to 1
      issue_request(ACT_UPDATE, 0, 0, 0);        // site 0 behind a busy site, q is zero
      issue_request(ACT_READ, 1, 0, 0);
      issue_request(ACT_READ, 1, 2, 0);
      drain();
      csr_write(CSR_UNUSED, $urandom_range(0, 131071));

      // Random phases, each under its own register setting. Shrinking the ring between
      // phases leaves the sweep pointer beyond it, which must restart at site 0.
      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         if (phase == PHASES - 1) begin
            p_free    = $urandom_range(0, 131071);
            p_blocked = $urandom_range(0, 131071);
            len       = $urandom_range(0, 511);
         end else begin
            p_free    = phase_free[phase];
            p_blocked = phase_blocked[phase];
            len       = phase_len[phase];
         end
         csr_write(CSR_HOP_PROB_FREE, p_free);
         csr_write(CSR_HOP_PROB_BLOCKED, p_blocked);
         csr_write(CSR_SITES_IN_USE, len);
         // In the first phase the response side holds off for a long stretch while the
         // sender keeps offering words back to back, so the block fills and stalls.
         if (phase == 0) begin
            pressure_on = 1'b1;
            hold_rsp    = 1'b1;
         end
         for (n = 0; n < ITEMS_PER_PHASE; n++) random_item();
         pressure_on = 1'b0;
      end
      drain();

      if (sb.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
